// ----- hdl/sdec_pkg.sv -----
// Shared constants for the signed integer to decimal text converter.
package sdec_pkg;

  localparam int unsigned DAB_STEP = 4;

  localparam logic [3:0] DAB_THRESH = 4'd5;
  localparam logic [3:0] DAB_ADJ    = 4'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

endpackage : sdec_pkg

// ----- hdl/signed_int_to_decimal_ascii.sv -----
// Signed integer to decimal ASCII text converter, top level.
//
// Input channel: one beat carries in_number, a NUMBER_WIDTH-bit two's complement
// value, taken when in_valid is high and in_stall is low.
// Output channel: one beat per character, most significant first; a negative
// value starts with '-'. out_last_char marks the final beat of a number's text.
// Zero gives the single beat '0'; no leading zeros, no terminator.
// The first character of a number passes the sign and magnitude register, the
// double-dabble stage registers, the leading digit register and the emitter's
// output register. The conversion pipeline takes a number every cycle while its
// leading digit stage is empty or being loaded; the emitter sends a number's
// characters in turn and loads the next only after the last of the one before.
// The emitter's output register sets the sustained rate.
// Reset clears all valid bits and the emitter; nothing is sent until new input.
// While out_stall is high the output beat holds; in_stall rises once the busy
// emitter cannot load the leading digit stage. No beat is lost or repeated.
module signed_int_to_decimal_ascii
  import sdec_pkg::*;
#(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [NUMBER_WIDTH-1:0] in_number,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_character,
  output logic                    out_last_char
);

  localparam int DIGITS  = (NUMBER_WIDTH * 3) / 10 + 1;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int NSTAGES = (NUMBER_WIDTH + DAB_STEP - 1) / DAB_STEP;
  localparam int BIN_W   = NSTAGES * DAB_STEP;
  localparam int IDX_W   = $clog2(DIGITS);

  logic adv;

  // Sign and magnitude stage
  logic                    s0_valid_r;
  logic                    s0_neg_r;
  logic [BIN_W-1:0]        s0_bin_r;
  logic [NUMBER_WIDTH-1:0] mag;

  assign mag = in_number[NUMBER_WIDTH-1] ? (~in_number + 1'b1) : in_number;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_neg_r <= in_number[NUMBER_WIDTH-1];
      s0_bin_r <= BIN_W'(mag);
    end
  end

  // Double-dabble chain
  logic             dv    [NSTAGES+1];
  logic             dneg  [NSTAGES+1];
  logic [BIN_W-1:0] dbin  [NSTAGES+1];
  logic [BCD_W-1:0] dbcd  [NSTAGES+1];

  assign dv[0]   = s0_valid_r;
  assign dneg[0] = s0_neg_r;
  assign dbin[0] = s0_bin_r;
  assign dbcd[0] = '0;

  for (genvar g = 0; g < NSTAGES; g++) begin : g_dab
    sdec_dabble #(
      .BIN_W  (BIN_W),
      .DIGITS (DIGITS)
    ) u_dab (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (dv[g]),
      .in_neg    (dneg[g]),
      .in_bin    (dbin[g]),
      .in_bcd    (dbcd[g]),
      .out_valid (dv[g+1]),
      .out_neg   (dneg[g+1]),
      .out_bin   (dbin[g+1]),
      .out_bcd   (dbcd[g+1])
    );
  end

  // Leading digit stage
  logic             lz_valid_r;
  logic             lz_neg_r;
  logic [BCD_W-1:0] lz_bcd_r;
  logic [IDX_W-1:0] lz_lead_r, lz_lead_nxt;

  always_comb begin
    lz_lead_nxt = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (dbcd[NSTAGES][4*d +: 4] != 4'd0) begin
        lz_lead_nxt = IDX_W'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lz_valid_r <= 1'b0;
    end else if (adv) begin
      lz_valid_r <= dv[NSTAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lz_neg_r  <= dneg[NSTAGES];
      lz_bcd_r  <= dbcd[NSTAGES];
      lz_lead_r <= lz_lead_nxt;
    end
  end

  // Character emitter
  logic             busy_r;
  logic             sign_pend_r;
  logic [IDX_W-1:0] idx_r;
  logic [BCD_W-1:0] digits_r;
  logic             out_valid_r;
  logic [7:0]       out_character_r;
  logic             out_last_char_r;
  logic             load;
  logic             emit;
  logic [3:0]       cur_digit;

  assign load      = lz_valid_r && !busy_r;
  assign adv       = !lz_valid_r || load;
  assign in_stall  = !adv;
  assign emit      = busy_r && (!out_valid_r || !out_stall);
  assign cur_digit = digits_r[4*idx_r +: 4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      sign_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r      <= 1'b1;
        sign_pend_r <= lz_neg_r;
      end else if (emit) begin
        if (sign_pend_r) begin
          sign_pend_r <= 1'b0;
        end else if (idx_r == '0) begin
          busy_r <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx_r    <= lz_lead_r;
      digits_r <= lz_bcd_r;
    end else if (emit && !sign_pend_r && idx_r != '0) begin
      idx_r <= idx_r - 1'b1;
    end
    if (emit) begin
      if (sign_pend_r) begin
        out_character_r <= CHAR_MINUS;
        out_last_char_r <= 1'b0;
      end else begin
        out_character_r <= CHAR_ZERO | {4'd0, cur_digit};
        out_last_char_r <= (idx_r == '0);
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last_char = out_last_char_r;

endmodule : signed_int_to_decimal_ascii

// ----- hdl/sdec_dabble.sv -----
// One registered double-dabble stage: shifts DAB_STEP binary bits into the BCD digits.
module sdec_dabble
  import sdec_pkg::*;
#(
  parameter int BIN_W  = 32,
  parameter int DIGITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic                  in_neg,
  input  logic [BIN_W-1:0]      in_bin,
  input  logic [4*DIGITS-1:0]   in_bcd,
  output logic                  out_valid,
  output logic                  out_neg,
  output logic [BIN_W-1:0]      out_bin,
  output logic [4*DIGITS-1:0]   out_bcd
);

  localparam int BCD_W = 4 * DIGITS;

  logic                 valid_r;
  logic                 neg_r;
  logic [BIN_W-1:0]     bin_r,  bin_nxt;
  logic [BCD_W-1:0]     bcd_r,  bcd_nxt;

  always_comb begin
    logic [BIN_W-1:0] bin_v;
    logic [BCD_W-1:0] bcd_v;
    bin_v = in_bin;
    bcd_v = in_bcd;
    for (int s = 0; s < DAB_STEP; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd_v[4*d +: 4] >= DAB_THRESH) begin
          bcd_v[4*d +: 4] = bcd_v[4*d +: 4] + DAB_ADJ;
        end
      end
      bcd_v = {bcd_v[BCD_W-2:0], bin_v[BIN_W-1]};
      bin_v = {bin_v[BIN_W-2:0], 1'b0};
    end
    bin_nxt = bin_v;
    bcd_nxt = bcd_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_r <= in_neg;
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_neg   = neg_r;
  assign out_bin   = bin_r;
  assign out_bcd   = bcd_r;

endmodule : sdec_dabble

// ----- verif/tb_top.sv -----
// Testbench for signed_int_to_decimal_ascii: directed and random numbers, decimal text checked.
`timescale 1ns / 1ps

module tb_top
  import sdec_pkg::*;
();

  localparam int W          = 32;
  localparam int CLK_PERIOD = 12;
  localparam int HOLD_LEN   = 200;
  localparam int TAIL_WAIT  = 40;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } char_beat_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  logic [W-1:0] in_number;
  logic         out_valid;
  logic         out_stall;
  logic [7:0]   out_character;
  logic         out_last_char;

  char_beat_t pending_chars[$];
  int         errors        = 0;
  int         numbers_sent  = 0;
  int         negatives     = 0;
  int         chars_checked = 0;
  int         stall_cycles  = 0;
  bit         tx_idle_on    = 1'b1;
  bit         rx_idle_on    = 1'b1;
  int         hold_seq      = 0;

  signed_int_to_decimal_ascii #(.NUMBER_WIDTH(W)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_decimal_text(logic [W-1:0] number);
    logic [W-1:0] mag;
    logic [7:0]   text[$];
    char_beat_t   beat;
    bit           neg;
    neg = number[W-1];
    mag = neg ? (~number + 1'b1) : number;
    do begin
      text.push_front(CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) text.push_front(CHAR_MINUS);
    foreach (text[i]) begin
      beat.character = text[i];
      beat.last_char = (i == text.size() - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  task automatic send_number(input logic [W-1:0] number);
    int gap;
    gap = tx_idle_on ? gap_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_number <= number;
    do @(posedge clk); while (in_stall);
    push_decimal_text(number);
    numbers_sent++;
    if (number[W-1]) negatives++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_input();
    wait (pending_chars.size() == 0);
  endtask

  // Receiver: random stall gaps plus a long hold-off during the backpressure test.
  always @(negedge clk) begin
    static int gap_left  = 0;
    static int hold_left = 0;
    static int hold_seen = 0;
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      gap_left = rx_idle_on ? gap_len() : 0;
    end
  end

  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n && in_valid && in_stall) stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected beat: character %0d last_char %0b", out_character, out_last_char);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_character !== want.character) begin
          $error("character: expected %0d, got %0d", want.character, out_character);
          errors++;
        end
        if (out_last_char !== want.last_char) begin
          $error("last_char: expected %0b, got %0b", want.last_char, out_last_char);
          errors++;
        end
      end
    end
  end

  function automatic logic [W-1:0] rand_number();
    int unsigned pow10[10] = '{1, 10, 100, 1000, 10000, 100000, 1000000, 10000000,
                               100000000, 1000000000};
    logic [W-1:0] v;
    int           k;
    k = $urandom_range(1, 9);
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2:    v = $urandom_range(0, pow10[k] - 1);
      3:    v = pow10[k] + $urandom_range(0, 2) - 1;
      4:    v = {1'b1, {(W-1){1'b0}}} + $urandom_range(0, 15) - 8;
      default: v = W'(1) << $urandom_range(0, W - 1);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic test_directed();
    logic [W-1:0] vals[$] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'd2147483647, 32'h8000_0000, -32'sd2147483647, 32'd1000000000,
      32'd999999999, 32'd1999999999, -32'sd1000000000, 32'd12345,
      -32'sd98765, 32'h5555_5555, 32'hAAAA_AAAA, 32'd4294967295,
      -32'sd9, 32'd123456789};
    foreach (vals[i]) send_number(vals[i]);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_number(rand_number());
  endtask

  task automatic test_streaming();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (30) send_number(rand_number());
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Receiver holds off long while the sender keeps offering numbers.
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    hold_seq++;
    repeat (40) send_number(rand_number());
    tx_idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (10) send_number(rand_number());
    wait_drained();
    repeat (10) send_number(rand_number());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_number = '0;
    out_stall = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(120);
    test_backpressure();
    test_streaming();
    test_drain_pause();
    test_random(120);

    idle_input();
    wait (pending_chars.size() == 0);
    rx_idle_on = 1'b0;
    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $error("%0d characters never arrived", pending_chars.size());
      errors++;
    end

    $display("Converted %0d numbers (%0d negative, zero and both extremes included),",
             numbers_sent, negatives);
    $display("checked %0d characters; input held off for %0d cycles under backpressure.",
             chars_checked, stall_cycles);
    if (errors == 0) begin
      $display("signed_int_to_decimal_ascii test passed");
    end else begin
      $display("signed_int_to_decimal_ascii test failed");
    end
    $finish;
  end

  initial begin
    #(64'(CLK_PERIOD) * 64'd1_000_000);
    $display("signed_int_to_decimal_ascii test failed");
    $finish;
  end

endmodule
